@@ src/sfs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sfs_pkg;

	// Fixed geometry of the sequencer.
	localparam int ACCUM_BITS = 32;
	localparam int FRAME_W    = 12;
	localparam int FCOUNT_W   = 13;
	localparam int PERIOD_W   = 16;
	localparam int LOOP_W     = 9;
	localparam int CFG_DATA_W = 16;

	localparam logic [FCOUNT_W-1:0] MAX_FRAMES         = 13'd4096;
	localparam logic [PERIOD_W-1:0] MS_PER_FRAME_RESET = 16'd83;

	// Commands carried by an input item.
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_PLAY = 2'd1;
	localparam logic [1:0] CMD_STOP = 2'd2;
	localparam logic [1:0] CMD_NOP  = 2'd3;

	// Play modes.
	localparam logic [1:0] MODE_NORMAL   = 2'd0;
	localparam logic [1:0] MODE_PINGPONG = 2'd1;
	localparam logic [1:0] MODE_REVERSE  = 2'd2;

	// Configuration register indexes.
	localparam logic REG_FRAME_COUNT  = 1'b0;
	localparam logic REG_MS_PER_FRAME = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic apply_tick;
		logic load_out;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic tick_run;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

@@ src/sfs_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, most significant bit first.
module sfs_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [sfs_pkg::ACCUM_BITS-1:0]    dividend,
	input  wire logic [sfs_pkg::PERIOD_W-1:0]      divisor,
	output logic                                   done,
	output logic [sfs_pkg::ACCUM_BITS-1:0]         quotient
);

	localparam int CNT_W = $clog2(sfs_pkg::ACCUM_BITS + 1);

	logic [CNT_W-1:0]                 cnt_q;
	logic                             done_q;
	logic [sfs_pkg::PERIOD_W-1:0]     rem_q;
	logic [sfs_pkg::PERIOD_W-1:0]     div_q;
	logic [sfs_pkg::ACCUM_BITS-1:0]   quo_q;
	logic [sfs_pkg::PERIOD_W:0]       shifted;
	logic [sfs_pkg::PERIOD_W:0]       diff;
	logic                             ge;

	assign shifted = {rem_q, quo_q[sfs_pkg::ACCUM_BITS-1]};
	assign ge      = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(sfs_pkg::ACCUM_BITS);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[sfs_pkg::PERIOD_W-1:0] : shifted[sfs_pkg::PERIOD_W-1:0];
			quo_q <= {quo_q[sfs_pkg::ACCUM_BITS-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ src/sfs_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfs_datapath (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire sfs_pkg::ctrl_cmd_t                    cmd,
	output sfs_pkg::status_t                           status,
	input  wire logic [sfs_pkg::FCOUNT_W-1:0]          frame_count,
	input  wire logic [sfs_pkg::PERIOD_W-1:0]          ms_per_frame,
	input  wire logic [1:0]                            command,
	input  wire logic [15:0]                           elapsed_ms,
	input  wire logic [1:0]                            play_mode,
	input  wire logic signed [sfs_pkg::LOOP_W-1:0]     loop_count,
	input  wire logic                                  wait_end,
	input  wire logic                                  out_stall,
	output logic                                       out_valid,
	output logic [sfs_pkg::FRAME_W-1:0]                frame_index,
	output logic                                       pass_complete,
	output logic                                       running
);

	localparam int AW = sfs_pkg::ACCUM_BITS;
	localparam int FW = sfs_pkg::FRAME_W;

	// Captured item.
	logic [1:0]                          cmd_q;
	logic [15:0]                         elapsed_q;
	logic [1:0]                          mode_in_q;
	logic signed [sfs_pkg::LOOP_W-1:0]   loop_in_q;
	logic                                wait_q;

	// Sequencer state.
	logic [AW-1:0]                       accum_q;
	logic [FW-1:0]                       frame_q;
	logic                                back_q;
	logic [1:0]                          mode_q;
	logic signed [sfs_pkg::LOOP_W-1:0]   loops_q;
	logic                                stop_pend_q;
	logic                                done_q;

	// Output register.
	logic                                out_valid_q;
	logic [FW-1:0]                       out_frame_q;
	logic                                out_done_q;
	logic                                out_run_q;

	logic [sfs_pkg::FCOUNT_W-1:0]        n_frames;
	logic [FW-1:0]                       last;
	logic [AW-1:0]                       last_ext;
	logic [AW:0]                         sum;
	logic [AW-1:0]                       sat_sum;
	logic [sfs_pkg::PERIOD_W-1:0]        period;
	logic                                div_start;
	logic                                div_done;
	logic [AW-1:0]                       quo;
	logic [1:0]                          eff_mode;
	logic                                out_free;

	// Tick decision.
	logic [FW-1:0]                       t_frame;
	logic                                t_back;
	logic                                t_done;
	logic                                t_clr;
	logic                                t_eop;
	logic signed [sfs_pkg::LOOP_W-1:0]   eop_loops;

	// Last frame: the frame count is limited to the maximum and an empty animation ends at 0.
	assign n_frames = (frame_count > sfs_pkg::MAX_FRAMES) ? sfs_pkg::MAX_FRAMES : frame_count;
	assign last     = (n_frames == '0) ? '0 : FW'(n_frames - sfs_pkg::FCOUNT_W'(1));
	assign last_ext = {{(AW-FW){1'b0}}, last};

	assign sum     = {1'b0, accum_q} + {{(AW+1-16){1'b0}}, elapsed_q};
	assign sat_sum = sum[AW] ? {AW{1'b1}} : sum[AW-1:0];
	assign period  = (ms_per_frame == '0) ? sfs_pkg::PERIOD_W'(1) : ms_per_frame;

	assign div_start = cmd.exec && status.tick_run;

	sfs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sat_sum),
		.divisor  (period),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		eff_mode = (mode_in_q inside {sfs_pkg::MODE_NORMAL, sfs_pkg::MODE_PINGPONG})
			? mode_in_q : sfs_pkg::MODE_REVERSE;
	end

	always_comb begin
		if (stop_pend_q) begin
			eop_loops = '0;
		end else if (!loops_q[sfs_pkg::LOOP_W-1] && loops_q != '0) begin
			eop_loops = loops_q - sfs_pkg::LOOP_W'(1);
		end else begin
			eop_loops = loops_q;
		end
	end

	always_comb begin
		t_frame = frame_q;
		t_back  = back_q;
		t_done  = 1'b0;
		t_clr   = 1'b0;
		t_eop   = 1'b0;
		if (!back_q) begin
			if (quo > last_ext) begin
				t_frame = last;
				if (mode_q == sfs_pkg::MODE_NORMAL) begin
					t_done = 1'b1;
					t_eop  = 1'b1;
				end else if (mode_q == sfs_pkg::MODE_PINGPONG) begin
					// Turn at the last frame: no pulse and no loop used.
					t_back = 1'b1;
					t_clr  = 1'b1;
				end
			end else begin
				t_frame = quo[FW-1:0];
			end
		end else begin
			if (quo >= last_ext) begin
				t_done  = 1'b1;
				t_eop   = 1'b1;
				t_frame = '0;
				if (mode_q == sfs_pkg::MODE_PINGPONG) begin
					t_back = 1'b0;
				end
			end else begin
				t_frame = last - quo[FW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q     <= command;
			elapsed_q <= elapsed_ms;
			mode_in_q <= play_mode;
			loop_in_q <= loop_count;
			wait_q    <= wait_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q     <= '0;
			frame_q     <= '0;
			back_q      <= 1'b0;
			mode_q      <= sfs_pkg::MODE_NORMAL;
			loops_q     <= '0;
			stop_pend_q <= 1'b0;
			done_q      <= 1'b0;
		end else if (cmd.exec) begin
			done_q <= 1'b0;
			case (cmd_q)
				sfs_pkg::CMD_TICK: begin
					if (status.tick_run) begin
						accum_q <= sat_sum;
					end
				end
				sfs_pkg::CMD_PLAY: begin
					accum_q     <= '0;
					stop_pend_q <= 1'b0;
					loops_q     <= loop_in_q[sfs_pkg::LOOP_W-1] ? '1 : loop_in_q;
					mode_q      <= eff_mode;
					if (eff_mode == sfs_pkg::MODE_REVERSE) begin
						back_q  <= 1'b1;
						frame_q <= last;
					end else begin
						back_q  <= 1'b0;
						frame_q <= '0;
					end
				end
				sfs_pkg::CMD_STOP: begin
					if (wait_q) begin
						stop_pend_q <= 1'b1;
					end else begin
						loops_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.apply_tick) begin
			frame_q <= t_frame;
			back_q  <= t_back;
			done_q  <= t_done;
			if (t_clr || t_eop) begin
				accum_q <= '0;
			end
			if (t_eop) begin
				loops_q <= eop_loops;
			end
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_frame_q <= frame_q;
			out_done_q  <= done_q;
			out_run_q   <= (loops_q != '0);
		end
	end

	assign status.tick_run = (cmd_q == sfs_pkg::CMD_TICK) && (loops_q != '0);
	assign status.div_done = div_done;
	assign status.out_free = out_free;

	assign out_valid     = out_valid_q;
	assign frame_index   = out_frame_q;
	assign pass_complete = out_done_q;
	assign running       = out_run_q;

`ifndef ASSERT_OFF
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> out_free)
		else $error("output register loaded while a result is still held");

	a_done_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && done_q) |-> cmd_q == sfs_pkg::CMD_TICK)
		else $error("pass completion raised by a command other than tick");
`endif

endmodule

`default_nettype wire

@@ src/sfs_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfs_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire sfs_pkg::status_t    status,
	output sfs_pkg::ctrl_cmd_t       cmd
);

	sfs_pkg::state_t state_q;
	sfs_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sfs_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = sfs_pkg::ST_EXEC;
				end
			end
			sfs_pkg::ST_EXEC: begin
				state_d = status.tick_run ? sfs_pkg::ST_DIV : sfs_pkg::ST_DONE;
			end
			sfs_pkg::ST_DIV: begin
				if (status.div_done) begin
					state_d = sfs_pkg::ST_DONE;
				end
			end
			sfs_pkg::ST_DONE: begin
				if (status.out_free) begin
					state_d = sfs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sfs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			sfs_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			sfs_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			sfs_pkg::ST_DIV: begin
				cmd.apply_tick = status.div_done;
			end
			sfs_pkg::ST_DONE: begin
				cmd.load_out = status.out_free;
			end
			default: begin
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sfs_pkg::ST_EXEC |=>
			(state_q == sfs_pkg::ST_DIV || state_q == sfs_pkg::ST_DONE))
		else $error("command execution did not move on after one cycle");

	a_div_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sfs_pkg::ST_DIV && status.div_done) |=> state_q == sfs_pkg::ST_DONE)
		else $error("quotient ready but tick result not applied");
`endif

endmodule

`default_nettype wire

@@ src/sprite_frame_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Animation frame sequencer.
// Input channel (in_valid / in_stall): one item per command. A tick adds
// elapsed_ms to the frame timer while loops remain; play restarts the
// sequence in the given mode and loop count; stop halts it at once or at
// the end of the current pass. Every item produces exactly one result item
// on the output channel (out_valid / out_stall): the frame to show, a pass
// completion pulse and the running flag.
// A tick while running waits for the restoring divider, which produces one
// quotient bit per cycle over the 32 bit timer; no new item is accepted until
// its result is loaded into the output register. Play, stop, unused commands
// and ticks while stopped skip the divider.
// The output register decouples the two sides: a new item is accepted while
// a finished result is still held. If the receiver keeps stalling, the next
// result waits inside the block and in_stall stays high until it is taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong in idle periods. Reset clears the sequencer to stopped at frame 0
// with a frame count of 0 and a frame period of 83 ms.
module sprite_frame_sequencer (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [1:0]                            command,
	input  wire logic [15:0]                           elapsed_ms,
	input  wire logic [1:0]                            play_mode,
	input  wire logic signed [sfs_pkg::LOOP_W-1:0]     loop_count,
	input  wire logic                                  wait_end,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [sfs_pkg::FRAME_W-1:0]                frame_index,
	output logic                                       pass_complete,
	output logic                                       running,
	input  wire logic                                  cfg_we,
	input  wire logic                                  cfg_index,
	input  wire logic [sfs_pkg::CFG_DATA_W-1:0]        cfg_data
);

	// Configuration registers.
	logic [sfs_pkg::FCOUNT_W-1:0] frame_count_q;
	logic [sfs_pkg::PERIOD_W-1:0] ms_per_frame_q;

	sfs_pkg::ctrl_cmd_t cmd;
	sfs_pkg::status_t   status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q  <= '0;
			ms_per_frame_q <= sfs_pkg::MS_PER_FRAME_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				sfs_pkg::REG_FRAME_COUNT: begin
					frame_count_q <= cfg_data[sfs_pkg::FCOUNT_W-1:0];
				end
				sfs_pkg::REG_MS_PER_FRAME: begin
					ms_per_frame_q <= cfg_data[sfs_pkg::PERIOD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The controller sequences each item; the datapath holds the timer,
	// the divider and the output register.
	sfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	sfs_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.frame_count   (frame_count_q),
		.ms_per_frame  (ms_per_frame_q),
		.command       (command),
		.elapsed_ms    (elapsed_ms),
		.play_mode     (play_mode),
		.loop_count    (loop_count),
		.wait_end      (wait_end),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.frame_index   (frame_index),
		.pass_complete (pass_complete),
		.running       (running)
	);

endmodule

`default_nettype wire

@@ test/sprite_frame_sequencer_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the animation frame sequencer.
//
// A short scripted sequence runs first: it covers the state after reset, the empty
// animation, a zero frame period, an oversized frame count, the unused play mode and
// command, both forms of endless loop count, and ping-pong turns with and without a
// pending stop. The random phases that follow each reprogramme the two registers while
// the block is idle, start the animation with a play item and then mostly send ticks.
// Tick sizes are scaled to the frame period so that passes end often. A behavioural
// model of the sequencer, kept in step with every accepted item, predicts each result.
// Results are compared field by field in arrival order.
module sprite_frame_sequencer_tb;

	localparam int RANDOM_PHASES   = 20;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int LONG_HOLD       = 300;
	localparam int QUIET_LIMIT     = 4000;
	localparam int SETTLE_CYCLES   = 40;
	localparam int N_ROWS          = 29;

	typedef struct packed {
		logic [sfs_pkg::FRAME_W-1:0] frame;
		logic                        done;
		logic                        run;
	} frame_result_t;

	// One row of the script is either an item or a write of both registers. In a
	// register row, arg carries the frame count and period the frame period.
	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t     kind;
		logic [1:0]    cmd;
		logic [15:0]   arg;
		logic [1:0]    mode;
		logic [8:0]    loops;
		logic          wait_e;
		logic [15:0]   period;
		logic          typed;
		frame_result_t want;
	} script_row_t;

	logic                               clk           = 1'b0;
	logic                               arst_n        = 1'b0;
	logic                               in_valid      = 1'b0;
	logic                               in_stall;
	logic [1:0]                         command       = sfs_pkg::CMD_NOP;
	logic [15:0]                        elapsed_ms    = '0;
	logic [1:0]                         play_mode     = sfs_pkg::MODE_NORMAL;
	logic signed [sfs_pkg::LOOP_W-1:0]  loop_count    = '0;
	logic                               wait_end      = 1'b0;
	logic                               out_valid;
	logic                               out_stall     = 1'b0;
	logic [sfs_pkg::FRAME_W-1:0]        frame_index;
	logic                               pass_complete;
	logic                               running;
	logic                               cfg_we        = 1'b0;
	logic                               cfg_index     = sfs_pkg::REG_FRAME_COUNT;
	logic [sfs_pkg::CFG_DATA_W-1:0]     cfg_data      = '0;

	sprite_frame_sequencer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.elapsed_ms    (elapsed_ms),
		.play_mode     (play_mode),
		.loop_count    (loop_count),
		.wait_end      (wait_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_index   (frame_index),
		.pass_complete (pass_complete),
		.running       (running),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Model state. loops_to_go is -1 for an endless animation and 0 when stopped.
	logic [sfs_pkg::FCOUNT_W-1:0]  cfg_frames;
	logic [sfs_pkg::PERIOD_W-1:0]  cfg_period;
	logic [31:0]                   acc_ms;
	logic [sfs_pkg::FRAME_W-1:0]   shown_frame;
	logic                          reversing;
	logic [1:0]                    anim_mode;
	int                            loops_to_go;
	logic                          stop_at_end;

	frame_result_t pending_frames[$];
	int            mismatches  = 0;
	int            quiet_cycles = 0;
	int            hold_asks   = 0;
	int            hold_served = 0;
	int            rx_wait     = 0;
	bit            calm        = 1'b0;

	// The script. Rows with typed set carry a result that follows directly from the
	// item; the others are checked against the model alone.
	script_row_t script [0:N_ROWS-1] = '{
		// Stopped after reset: ticks and the unused command change nothing.
		'{ROW_ITEM, sfs_pkg::CMD_TICK, 16'd100, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'd0,
			1'b1, '{12'd0, 1'b0, 1'b0}},
		'{ROW_ITEM, sfs_pkg::CMD_NOP, 16'hFFFF, 2'd3, 9'h1FF, 1'b1, 16'd0,
			1'b1, '{12'd0, 1'b0, 1'b0}},
		// Empty animation with the reset period of 83 ms: one pass ends on the
		// first tick that reaches a whole frame.
		'{ROW_ITEM, sfs_pkg::CMD_PLAY, 16'd0, sfs_pkg::MODE_NORMAL, 9'd1, 1'b0, 16'd0,
			1'b1, '{12'd0, 1'b0, 1'b1}},
		'{ROW_ITEM, sfs_pkg::CMD_TICK, 16'd82, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'd0,
			1'b1, '{12'd0, 1'b0, 1'b1}},
		'{ROW_ITEM, sfs_pkg::CMD_TICK, 16'd1, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'd0,
			1'b1, '{12'd0, 1'b1, 1'b0}},
		// Largest animation, zero frame period taken as one millisecond.
		'{ROW_CFG, sfs_pkg::CMD_NOP, 16'd4096, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'd0,
			1'b0, '{12'd0, 1'b0, 1'b0}},
		'{ROW_ITEM, sfs_pkg::CMD_PLAY, 16'd0, sfs_pkg::MODE_PINGPONG, 9'h1FF, 1'b0, 16'd0,
			1'b1, '{12'd0, 1'b0, 1'b1}},
		'{ROW_ITEM, sfs_pkg::CMD_TICK, 16'hFFFF, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'd0,
			1'b1, '{12'd4095, 1'b0, 1'b1}},
		'{ROW_ITEM, sfs_pkg::CMD_TICK, 16'd4095, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'd0,
			1'b1, '{12'd0, 1'b1, 1'b1}},
		// A stop at the end of the pass is not applied at the ping-pong turn.
		'{ROW_ITEM, sfs_pkg::CMD_STOP, 16'd0, sfs_pkg::MODE_NORMAL, 9'd0, 1'b1, 16'd0,
			1'b1, '{12'd0, 1'b0, 1'b1}},
		'{ROW_ITEM, sfs_pkg::CMD_TICK, 16'hFFFF, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'd0,
			1'b1, '{12'd4095, 1'b0, 1'b1}},
		'{ROW_ITEM, sfs_pkg::CMD_TICK, 16'hFFFF, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'd0,
			1'b1, '{12'd0, 1'b1, 1'b0}},
		// Frame count beyond the maximum, longest frame period.
		'{ROW_CFG, sfs_pkg::CMD_NOP, 16'd8191, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'hFFFF,
			1'b0, '{12'd0, 1'b0, 1'b0}},
		'{ROW_ITEM, sfs_pkg::CMD_PLAY, 16'd0, 2'd3, 9'd255, 1'b0, 16'd0,
			1'b1, '{12'd4095, 1'b0, 1'b1}},
		'{ROW_ITEM, sfs_pkg::CMD_TICK, 16'hFFFF, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'd0,
			1'b0, '{12'd0, 1'b0, 1'b0}},
		'{ROW_ITEM, sfs_pkg::CMD_STOP, 16'd0, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'd0,
			1'b1, '{12'd4094, 1'b0, 1'b0}},
		// A loop count of zero leaves the sequencer stopped.
		'{ROW_ITEM, sfs_pkg::CMD_PLAY, 16'd0, sfs_pkg::MODE_REVERSE, 9'd0, 1'b0, 16'd0,
			1'b1, '{12'd4095, 1'b0, 1'b0}},
		'{ROW_ITEM, sfs_pkg::CMD_TICK, 16'hFFFF, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'd0,
			1'b1, '{12'd4095, 1'b0, 1'b0}},
		// The most negative loop count is endless as well.
		'{ROW_ITEM, sfs_pkg::CMD_PLAY, 16'd0, sfs_pkg::MODE_NORMAL, 9'h100, 1'b0, 16'd0,
			1'b1, '{12'd0, 1'b0, 1'b1}},
		'{ROW_ITEM, sfs_pkg::CMD_TICK, 16'hFFFF, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'd0,
			1'b0, '{12'd0, 1'b0, 1'b0}},
		// Three frames of one millisecond; the upper data bits are not stored.
		'{ROW_CFG, sfs_pkg::CMD_NOP, 16'hE003, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'd1,
			1'b0, '{12'd0, 1'b0, 1'b0}},
		'{ROW_ITEM, sfs_pkg::CMD_PLAY, 16'd0, sfs_pkg::MODE_NORMAL, 9'd2, 1'b0, 16'd0,
			1'b0, '{12'd0, 1'b0, 1'b0}},
		'{ROW_ITEM, sfs_pkg::CMD_TICK, 16'd2, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'd0,
			1'b0, '{12'd0, 1'b0, 1'b0}},
		'{ROW_ITEM, sfs_pkg::CMD_TICK, 16'd1, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'd0,
			1'b0, '{12'd0, 1'b0, 1'b0}},
		'{ROW_ITEM, sfs_pkg::CMD_TICK, 16'd7, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'd0,
			1'b0, '{12'd0, 1'b0, 1'b0}},
		'{ROW_ITEM, sfs_pkg::CMD_PLAY, 16'd0, sfs_pkg::MODE_PINGPONG, 9'd1, 1'b0, 16'd0,
			1'b0, '{12'd0, 1'b0, 1'b0}},
		'{ROW_ITEM, sfs_pkg::CMD_TICK, 16'd3, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'd0,
			1'b0, '{12'd0, 1'b0, 1'b0}},
		'{ROW_ITEM, sfs_pkg::CMD_TICK, 16'd1, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'd0,
			1'b0, '{12'd0, 1'b0, 1'b0}},
		'{ROW_ITEM, sfs_pkg::CMD_TICK, 16'd1, sfs_pkg::MODE_NORMAL, 9'd0, 1'b0, 16'd0,
			1'b0, '{12'd0, 1'b0, 1'b0}}
	};

	// Index of the final frame: an empty animation uses frame 0 and an oversized
	// count is clipped to the maximum.
	function automatic logic [31:0] final_frame();
		logic [31:0] n;
		n = cfg_frames;
		if (n > sfs_pkg::MAX_FRAMES)
			n = sfs_pkg::MAX_FRAMES;
		return (n == 0) ? 32'd0 : n - 1;
	endfunction

	function automatic void close_pass();
		if (loops_to_go > 0)
			loops_to_go--;
		acc_ms = '0;
		if (stop_at_end)
			loops_to_go = 0;
	endfunction

	// Applies one item to the model and returns the result it should produce.
	function automatic frame_result_t step_sequencer(input logic [1:0] cmd,
			input logic [15:0] el, input logic [1:0] md, input logic [8:0] lc,
			input logic we);
		logic [32:0]   sum;
		logic [31:0]   per;
		logic [31:0]   q;
		logic [31:0]   last;
		frame_result_t res;
		res.done = 1'b0;
		last = final_frame();
		case (cmd)
			sfs_pkg::CMD_TICK: begin
				if (loops_to_go != 0) begin
					// The accumulator saturates rather than wrapping.
					sum = {1'b0, acc_ms} + el;
					acc_ms = sum[32] ? '1 : sum[31:0];
					per = (cfg_period == 0) ? 32'd1 : 32'(cfg_period);
					q = acc_ms / per;
					if (!reversing) begin
						if (q > last) begin
							shown_frame = last[sfs_pkg::FRAME_W-1:0];
							if (anim_mode == sfs_pkg::MODE_NORMAL) begin
								res.done = 1'b1;
								close_pass();
							end else if (anim_mode == sfs_pkg::MODE_PINGPONG) begin
								// Turning at the last frame uses no loop.
								reversing = 1'b1;
								acc_ms = '0;
							end
						end else begin
							shown_frame = q[sfs_pkg::FRAME_W-1:0];
						end
					end else if (q >= last) begin
						res.done = 1'b1;
						if (anim_mode == sfs_pkg::MODE_PINGPONG)
							reversing = 1'b0;
						shown_frame = '0;
						close_pass();
					end else begin
						shown_frame = 12'(last - q);
					end
				end
			end
			sfs_pkg::CMD_PLAY: begin
				acc_ms = '0;
				stop_at_end = 1'b0;
				loops_to_go = lc[8] ? -1 : int'(lc);
				anim_mode = (md == 2'd3) ? sfs_pkg::MODE_REVERSE : md;
				if (anim_mode == sfs_pkg::MODE_REVERSE) begin
					reversing = 1'b1;
					shown_frame = last[sfs_pkg::FRAME_W-1:0];
				end else begin
					reversing = 1'b0;
					shown_frame = '0;
				end
			end
			sfs_pkg::CMD_STOP: begin
				if (we)
					stop_at_end = 1'b1;
				else
					loops_to_go = 0;
			end
			default: ;
		endcase
		res.frame = shown_frame;
		res.run = (loops_to_go != 0);
		return res;
	endfunction

	// Offers one item after a random gap and records its expected result once the
	// block has taken it. A row with a typed result supplies that result instead.
	task automatic offer_item(input logic [1:0] cmd, input logic [15:0] el,
			input logic [1:0] md, input logic [8:0] lc, input logic we,
			input logic typed, input frame_result_t want);
		int            gap;
		frame_result_t res;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		elapsed_ms <= el;
		play_mode  <= md;
		loop_count <= lc;
		wait_end   <= we;
		do
			@(posedge clk);
		while (in_stall);
		res = step_sequencer(cmd, el, md, lc, we);
		pending_frames.insert(pending_frames.size(), typed ? want : res);
	endtask

	// Withdraws the input and waits until every expected result has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
	endtask

	// Writes both registers on consecutive edges, the enable held high between them.
	task automatic program_regs(input logic [15:0] frames, input logic [15:0] period);
		cfg_we    <= 1'b1;
		cfg_index <= sfs_pkg::REG_FRAME_COUNT;
		cfg_data  <= frames;
		@(posedge clk);
		cfg_frames = frames[sfs_pkg::FCOUNT_W-1:0];
		cfg_index <= sfs_pkg::REG_MS_PER_FRAME;
		cfg_data  <= period;
		@(posedge clk);
		cfg_period = period;
		cfg_we    <= 1'b0;
	endtask

	// Mostly short finite runs, with a share of endless, zero and arbitrary counts.
	function automatic logic [8:0] pick_loops();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 9'($urandom_range(1, 4));
		else if (r < 75)
			return 9'h1FF;
		else if (r < 85)
			return 9'd0;
		return 9'($urandom);
	endfunction

	// Receiver: a random stall after each item taken, or a long hold-off on request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_asks != hold_served) begin
				hold_served = hold_served + 1;
				rx_wait = LONG_HOLD;
			end else if (out_valid && !out_stall) begin
				rx_wait = calm ? 0 : $urandom_range(0, 4);
			end else if (rx_wait != 0) begin
				rx_wait = rx_wait - 1;
			end
			out_stall <= (rx_wait != 0);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_frames.size() == 0) begin
				$display("%0t: unexpected result, frame_index %0d pass_complete %0d running %0d",
					$time, frame_index, pass_complete, running);
				mismatches++;
			end else begin
				want = pending_frames.pop_front();
				if (frame_index !== want.frame) begin
					$display("%0t: frame_index expected %0d, got %0d",
						$time, want.frame, frame_index);
					mismatches++;
				end
				if (pass_complete !== want.done) begin
					$display("%0t: pass_complete expected %0d, got %0d",
						$time, want.done, pass_complete);
					mismatches++;
				end
				if (running !== want.run) begin
					$display("%0t: running expected %0d, got %0d",
						$time, want.run, running);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: too long without any item moving on either side ends the run.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
			$display("sprite_frame_sequencer: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		logic [15:0]   frames;
		logic [15:0]   period;
		logic [1:0]    cmd;
		logic [15:0]   el;
		logic [8:0]    lc;
		longint        span;
		longint        hi;
		int            r;
		frame_result_t none;

		none = '0;
		cfg_frames   = '0;
		cfg_period   = sfs_pkg::MS_PER_FRAME_RESET;
		acc_ms       = '0;
		shown_frame  = '0;
		reversing    = 1'b0;
		anim_mode    = sfs_pkg::MODE_NORMAL;
		loops_to_go  = 0;
		stop_at_end  = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Scripted part. Register rows wait for the block to go idle first.
		for (int i = 0; i < N_ROWS; i++) begin
			if (script[i].kind == ROW_CFG) begin
				drain_results();
				program_regs(script[i].arg, script[i].period);
			end else begin
				offer_item(script[i].cmd, script[i].arg, script[i].mode,
					script[i].loops, script[i].wait_e, script[i].typed, script[i].want);
			end
		end

		// Random phases. Each starts from an idle block with a fresh setting and a
		// play item, so most ticks land on a running animation.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_results();
			calm = (ph % 4 == 3);
			case ($urandom_range(0, 9))
				0: frames = 16'd0;
				1: frames = 16'd1;
				2: frames = 16'd4096;
				3: frames = 16'($urandom_range(4097, 8191));
				4: frames = 16'($urandom_range(0, 8191));
				default: frames = 16'($urandom_range(2, 16));
			endcase
			case ($urandom_range(0, 9))
				0: period = 16'd0;
				1: period = 16'd1;
				2: period = 16'hFFFF;
				3: period = 16'($urandom);
				default: period = 16'($urandom_range(1, 100));
			endcase
			program_regs(frames, period);
			offer_item(sfs_pkg::CMD_PLAY, 16'($urandom), 2'($urandom), pick_loops(),
				1'($urandom), 1'b0, none);

			for (int n = 1; n < ITEMS_PER_PHASE; n++) begin
				// A long hold-off at the receiver while items keep coming, so that
				// the block fills up and stalls its input.
				if (ph == 5 && n == 50)
					hold_asks <= hold_asks + 1;
				// Once, the sender waits for every outstanding result.
				if (ph == 10 && n == 50)
					drain_results();

				// Tick sizes follow the length of one pass so that passes end often.
				span = longint'((cfg_period == 0) ? 1 : cfg_period) * (final_frame() + 1);
				hi = span / 3 + 1;
				if (hi > 65535)
					hi = 65535;
				el = ($urandom_range(0, 99) < 12) ? 16'($urandom)
					: 16'($urandom_range(0, int'(hi)));

				r = $urandom_range(0, 99);
				if (r < 80)
					cmd = sfs_pkg::CMD_TICK;
				else if (r < 90)
					cmd = sfs_pkg::CMD_PLAY;
				else if (r < 97)
					cmd = sfs_pkg::CMD_STOP;
				else
					cmd = sfs_pkg::CMD_NOP;
				lc = (cmd == sfs_pkg::CMD_PLAY) ? pick_loops() : 9'($urandom);
				offer_item(cmd, el, 2'($urandom), lc, 1'($urandom), 1'b0, none);
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("sprite_frame_sequencer: match");
		else
			$display("sprite_frame_sequencer: mismatch");
		$finish;
	end

endmodule
